// ----- rtl/depq_pkg.sv -----
// Package for the double-ended priority queue: item types, operation codes
// and the command/status structs between controller and datapath. No dependencies.
package depq_pkg;

    localparam logic [1:0] OP_INSERT     = 2'd0;
    localparam logic [1:0] OP_REMOVE_MAX = 2'd1;
    localparam logic [1:0] OP_REMOVE_MIN = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic               overflow;
    } out_t;

    typedef struct packed {
        logic load;
        logic set_ovf;
        logic rd_prev;
        logic shift;
        logic place;
        logic rm_max;
        logic rm_min;
        logic clear;
        logic rd_min;
        logic rd_max;
        logic cap_min;
        logic cap_max;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       hole_at_head;
        logic       greater;
        logic       out_free;
    } sts_t;

endpackage

// ----- rtl/double_ended_priority_queue_top.sv -----
// Top level of the double-ended priority queue.
// Depends on depq_pkg, depq_ctrl, depq_dp.
//
// Input channel s_valid/s_ready/s_data carries one operation per transaction:
// insert, remove maximum, remove minimum or clear. Every accepted transaction
// yields exactly one result on m_valid/m_ready/m_data with the maximum,
// minimum, empty flag and insert-overflow flag after the operation.
// Values sit in a circular, ascending store in one RAM; the minimum is at the
// head pointer and the maximum at head plus count minus one.
// Steps after acceptance: dispatch, then for an insert that is not dropped one
// shift step per stored value larger than the new one, each step one RAM read
// then one write, until the new value is placed (at once if the hole is at the
// head); then the minimum and maximum are read and the result is loaded.
// One transaction at a time: s_ready is high only when idle, from the cycle
// after the result is loaded.
// The result register holds while m_ready is low; the block waits in its
// final step until that register is free.
// Reset (aresetn low, synchronous) empties the store at once; no clearing
// pass is needed.
module double_ended_priority_queue_top import depq_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);
    cmd_t cmd;
    sts_t sts;

    depq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    depq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

// ----- rtl/depq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module depq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/depq_ctrl.sv -----
// Controller state machine of the double-ended priority queue.
// Depends on depq_pkg; drives depq_dp through cmd_t and reads sts_t.
module depq_ctrl import depq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_INS_CHK  = 3'd2;
    localparam logic [2:0] ST_INS_WAIT = 3'd3;
    localparam logic [2:0] ST_RD_MIN   = 3'd4;
    localparam logic [2:0] ST_RD_MAX   = 3'd5;
    localparam logic [2:0] ST_CAP_MAX  = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_RD_MIN;
                case (sts.op)
                    OP_INSERT: begin
                        if (sts.full) begin
                            cmd.set_ovf = 1'b1;
                        end else begin
                            state_next = ST_INS_CHK;
                        end
                    end
                    OP_REMOVE_MAX: cmd.rm_max = 1'b1;
                    OP_REMOVE_MIN: cmd.rm_min = 1'b1;
                    default:       cmd.clear  = 1'b1;
                endcase
            end
            ST_INS_CHK: begin
                if (sts.hole_at_head) begin
                    cmd.place  = 1'b1;
                    state_next = ST_RD_MIN;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_INS_WAIT;
                end
            end
            ST_INS_WAIT: begin
                if (sts.greater) begin
                    cmd.shift  = 1'b1;
                    state_next = ST_INS_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_RD_MIN;
                end
            end
            ST_RD_MIN: begin
                cmd.rd_min = 1'b1;
                state_next = ST_RD_MAX;
            end
            ST_RD_MAX: begin
                cmd.cap_min = 1'b1;
                cmd.rd_max  = 1'b1;
                state_next  = ST_CAP_MAX;
            end
            ST_CAP_MAX: begin
                cmd.cap_max = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ----- rtl/depq_dp.sv -----
// Datapath of the double-ended priority queue: circular sorted store,
// pointers, compare and output register. Depends on depq_pkg and depq_ram.
module depq_dp import depq_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic aclk,
    input  logic aresetn,
    input  in_t  s_data,
    input  cmd_t cmd,
    output sts_t sts,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] hole_reg, hole_next;
    in_t           item_reg;
    logic          ovf_reg;
    logic [31:0]   min_reg, max_reg;
    logic          out_valid_reg;
    out_t          out_reg;

    logic [CW:0]   end_sum;
    logic [AW-1:0] end_ptr, hole_dec, tail_ptr, head_inc;
    logic [AW-1:0] raddr, waddr;
    logic [31:0]   wdata, rdata;
    logic          we, re;

    always_comb begin
        end_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
        if (end_sum >= (CW + 1)'(CAPACITY)) begin
            end_sum = end_sum - (CW + 1)'(CAPACITY);
        end
        end_ptr  = end_sum[AW-1:0];
        tail_ptr = (end_ptr == '0) ? LAST : end_ptr - AW'(1);
        hole_dec = (hole_reg == '0) ? LAST : hole_reg - AW'(1);
        head_inc = (head_reg == LAST) ? '0 : head_reg + AW'(1);
    end

    assign re    = cmd.rd_prev | cmd.rd_min | cmd.rd_max;
    assign raddr = cmd.rd_prev ? hole_dec : (cmd.rd_min ? head_reg : tail_ptr);
    assign we    = cmd.shift | cmd.place;
    assign waddr = hole_reg;
    assign wdata = cmd.shift ? rdata : item_reg.value;

    depq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        hole_next  = hole_reg;
        if (cmd.load) begin
            hole_next = end_ptr;
        end
        if (cmd.shift) begin
            hole_next = hole_dec;
        end
        if (cmd.place) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.rm_max && count_reg != '0) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.rm_min && count_reg != '0) begin
            count_next = count_reg - CW'(1);
            head_next  = head_inc;
        end
        if (cmd.clear) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg <= hole_next;
        if (cmd.load) begin
            item_reg <= s_data;
            ovf_reg  <= 1'b0;
        end
        if (cmd.set_ovf) begin
            ovf_reg <= 1'b1;
        end
        if (cmd.cap_min) begin
            min_reg <= rdata;
        end
        if (cmd.cap_max) begin
            max_reg <= rdata;
        end
        if (cmd.emit) begin
            out_reg.is_empty  <= (count_reg == '0);
            out_reg.overflow  <= ovf_reg;
            out_reg.min_value <= (count_reg == '0) ? '0 : $signed(min_reg);
            out_reg.max_value <= (count_reg == '0) ? '0 : $signed(max_reg);
        end
    end

    assign sts.op           = item_reg.operation;
    assign sts.full         = (count_reg == CW'(CAPACITY));
    assign sts.hole_at_head = (hole_reg == head_reg);
    assign sts.greater      = ($signed(rdata) > item_reg.value);
    assign sts.out_free     = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// ----- rtl/depq_checker.sv -----
// Port-level checks for the double-ended priority queue, bound to the top.
// Depends on depq_pkg.
module depq_port_checks import depq_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |-> m_data.max_value == 0 && m_data.min_value == 0)
        else $error("empty result not zero");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_empty |-> m_data.min_value <= m_data.max_value)
        else $error("minimum above maximum");

    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |-> !m_data.is_empty)
        else $error("overflow on empty store");
endmodule

bind double_ended_priority_queue_top depq_port_checks u_depq_port_checks (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/depq_checker.sv -----
// Checker for the double-ended priority queue: watches both channels, predicts
// each result from a sorted copy of the store and counts mismatches. Uses depq_pkg.
`timescale 1ns / 1ps
module depq_checker import depq_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   results_pending
);

    logic signed [31:0] sorted_values[$];
    out_t               expected_results[$];

    function automatic out_t apply_operation(in_t txn);
        out_t res;
        int   pos;
        res          = '0;
        res.overflow = 1'b0;
        case (txn.operation)
            OP_INSERT: begin
                if (sorted_values.size() >= CAPACITY) begin
                    res.overflow = 1'b1;
                end else begin
                    pos = sorted_values.size();
                    while (pos > 0 && sorted_values[pos-1] > txn.value) pos--;
                    sorted_values.insert(pos, txn.value);
                end
            end
            OP_REMOVE_MAX: begin
                if (sorted_values.size() > 0) void'(sorted_values.pop_back());
            end
            OP_REMOVE_MIN: begin
                if (sorted_values.size() > 0) void'(sorted_values.pop_front());
            end
            default: begin
                sorted_values.delete();
            end
        endcase
        if (sorted_values.size() == 0) begin
            res.is_empty = 1'b1;
        end else begin
            res.max_value = sorted_values[sorted_values.size()-1];
            res.min_value = sorted_values[0];
            res.is_empty  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        out_t exp_res;
        if (!aresetn) begin
            fail_count      = 0;
            results_pending = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_data.max_value !== exp_res.max_value) begin
                        $display("%0t: max_value expected %0d actual %0d", $time,
                                 exp_res.max_value, m_data.max_value);
                        fail_count++;
                    end
                    if (m_data.min_value !== exp_res.min_value) begin
                        $display("%0t: min_value expected %0d actual %0d", $time,
                                 exp_res.min_value, m_data.min_value);
                        fail_count++;
                    end
                    if (m_data.is_empty !== exp_res.is_empty) begin
                        $display("%0t: is_empty expected %b actual %b", $time,
                                 exp_res.is_empty, m_data.is_empty);
                        fail_count++;
                    end
                    if (m_data.overflow !== exp_res.overflow) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 exp_res.overflow, m_data.overflow);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) expected_results.push_back(apply_operation(s_data));
            results_pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_double_ended_priority_queue_top.sv -----
// Testbench top for the double-ended priority queue: drives directed and random
// transactions with random idling and gives the verdict. Uses depq_pkg, depq_checker.
`timescale 1ns / 1ps
module tb_double_ended_priority_queue_top;
    import depq_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int CYCLE_LIMIT = 3000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic quiet = 1'b0;
    int   fail_count;
    int   results_pending;
    int   cycle_count = 0;

    double_ended_priority_queue_top #(.CAPACITY(CAPACITY)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    depq_checker #(.CAPACITY(CAPACITY)) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .results_pending(results_pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) m_ready <= quiet || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_txn(input logic [1:0] op, input logic signed [31:0] val);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.operation <= op;
        s_data.value     <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_pending != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom);
        endcase
    endfunction

    initial begin
        int          pick;
        logic [1:0]  op;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_txn(OP_REMOVE_MAX, 32'sd5);
        send_txn(OP_REMOVE_MIN, -32'sd1);
        send_txn(OP_CLEAR, 32'sd0);
        send_txn(OP_INSERT, 32'sh7fffffff);
        send_txn(OP_INSERT, 32'sh80000000);
        send_txn(OP_INSERT, 32'sd0);
        send_txn(OP_INSERT, -32'sd1);
        send_txn(OP_INSERT, 32'sd0);
        send_txn(OP_INSERT, 32'sd0);
        send_txn(OP_REMOVE_MAX, 32'sd0);
        send_txn(OP_REMOVE_MIN, 32'sh7fffffff);
        send_txn(OP_REMOVE_MIN, 32'sd0);
        send_txn(OP_REMOVE_MAX, 32'sd0);
        send_txn(OP_REMOVE_MAX, 32'sd0);
        send_txn(OP_REMOVE_MIN, 32'sd0);
        send_txn(OP_REMOVE_MIN, 32'sd0);
        send_txn(OP_INSERT, 32'sd1);
        send_txn(OP_CLEAR, 32'sh55555555);
        drain();

        for (int n = 0; n < 632; n++) begin
            quiet = (n >= 250 && n < 350);
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = OP_INSERT;
            else if (pick < 65) op = OP_REMOVE_MAX;
            else if (pick < 85) op = OP_REMOVE_MIN;
            else if (pick < 95) op = OP_CLEAR;
            else                op = 2'($urandom);
            send_txn(op, pick_value());
            if (n == 400) drain();
        end
        quiet = 1'b0;
        drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
